[hdl/swlis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlis_pkg
// Shared widths, register map and controller/datapath interface types for the
// sliding-window longest non-decreasing subsequence core.
// ----------------------------------------------------------------------------
package swlis_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);   // holds 0..MAX_WINDOW
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic REG_WINDOW_LEN = 1'b0;

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic push;       // item accepted: write sample, reset walk state
    logic walk;       // one element of the dynamic program
    logic load_out;   // copy result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;  // current walk cycle handles the newest element
  } dp_status_t;

endpackage

[hdl/swlis_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlis_ctrl
// Sequencer: accepts one item, walks the window one element a cycle, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module swlis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  swlis_pkg::dp_status_t status_i,
  output swlis_pkg::dp_cmd_t   cmd_o
);

  swlis_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q;
    cmd_o.push       = 1'b0;
    cmd_o.walk       = 1'b0;
    cmd_o.load_out   = 1'b0;
    in_stall_o       = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      swlis_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          state_d    = swlis_pkg::ST_WALK;
        end
      end
      swlis_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_last) begin
          state_d = swlis_pkg::ST_DONE;
        end
      end
      swlis_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = swlis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swlis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swlis_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/swlis_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlis_dp
// Window cells and run-length accumulators. Samples sit oldest-first in a
// row of cells. During the walk cell 0 holds the current element; it
// broadcasts its value and run length, later cells fold it into their
// accumulators, and the occupied cells rotate left by one.
// ----------------------------------------------------------------------------
module swlis_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swlis_pkg::dp_cmd_t                  cmd_i,
  output swlis_pkg::dp_status_t               status_o,
  input  logic                                cfg_clear_i,
  input  logic [swlis_pkg::CNT_W-1:0]         eff_len_i,
  input  logic signed [swlis_pkg::SAMPLE_W-1:0] sample_i,
  output logic [swlis_pkg::CNT_W-1:0]         lis_length_o,
  output logic [swlis_pkg::CNT_W-1:0]         window_fill_o
);

  localparam int N = swlis_pkg::MAX_WINDOW;
  localparam int W = swlis_pkg::CNT_W;

  logic signed [swlis_pkg::SAMPLE_W-1:0] val_q [N];
  logic signed [swlis_pkg::SAMPLE_W-1:0] val_d [N];
  logic [W-1:0] pre_q [N];
  logic [W-1:0] pre_d [N];
  logic [W-1:0] upd   [N];

  logic [W-1:0] fill_q, fill_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] best_q, best_d;
  logic [W-1:0] lis_q, wfill_q;
  logic [W-1:0] run_len;
  logic         full;

  assign full     = fill_q >= eff_len_i;
  assign run_len  = pre_q[0] + W'(1);

  always_comb begin
    fill_d = fill_q;
    rem_d  = rem_q;
    best_d = best_q;
    for (int k = 0; k < N; k++) begin
      val_d[k] = val_q[k];
      pre_d[k] = pre_q[k];
      // later elements still ahead in the walk take the broadcast run length
      if (k >= 1 && W'(k) < rem_q && val_q[0] <= val_q[k] && run_len > pre_q[k]) begin
        upd[k] = run_len;
      end else begin
        upd[k] = pre_q[k];
      end
    end

    if (cfg_clear_i) begin
      fill_d = '0;
    end else if (cmd_i.push) begin
      for (int k = 0; k < N; k++) begin
        pre_d[k] = '0;
        if (full) begin
          // drop the oldest, append at the end of the window
          if (W'(k + 1) < eff_len_i) begin
            val_d[k] = val_q[(k + 1) % N];
          end else if (W'(k + 1) == eff_len_i) begin
            val_d[k] = sample_i;
          end
        end else if (W'(k) == fill_q) begin
          val_d[k] = sample_i;
        end
      end
      fill_d = full ? eff_len_i : fill_q + W'(1);
      rem_d  = full ? eff_len_i : fill_q + W'(1);
      best_d = '0;
    end else if (cmd_i.walk) begin
      for (int k = 0; k < N; k++) begin
        if (W'(k + 1) < fill_q) begin
          val_d[k] = val_q[(k + 1) % N];
          pre_d[k] = upd[(k + 1) % N];
        end else if (W'(k + 1) == fill_q) begin
          val_d[k] = val_q[0];
          pre_d[k] = run_len;
        end
      end
      if (run_len > best_q) begin
        best_d = run_len;
      end
      rem_d = rem_q - W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rem_q  <= '0;
      best_q <= '0;
    end else begin
      fill_q <= fill_d;
      rem_q  <= rem_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      val_q[k] <= val_d[k];
      pre_q[k] <= pre_d[k];
    end
    if (cmd_i.load_out) begin
      lis_q   <= best_q;
      wfill_q <= fill_q;
    end
  end

  assign status_o.walk_last = (rem_q == W'(1));
  assign lis_length_o       = lis_q;
  assign window_fill_o      = wfill_q;

endmodule

[hdl/sliding_window_lis_length_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_lis_length_core
// Longest non-decreasing subsequence length over a sliding sample window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample_i with in_valid_i / in_stall_o. An item is taken
//   when in_valid_i is high and in_stall_o is low.
//   Output channel: lis_length_o and window_fill_o with out_valid_o /
//   out_stall_i, one result item per input item.
//   Each item is taken in the accept state, then the walk updates one element
//   per cycle across all cells for each element held in the window, then the
//   output register is loaded. The next item is taken right after.
//   A result waits in the output register while out_stall_i is high; the
//   core still accepts and walks the next item, and holds it in the final
//   state until the output register frees up.
//   APB register 0 (address 0): window_len, 7 bits; 0 acts as 1 and values
//   above 64 act as 64. Any write to it empties the window.
//   Reset: window empty, window_len = 64, no result pending.
// ----------------------------------------------------------------------------
module sliding_window_lis_length_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input channel
  input  logic signed [swlis_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  // output channel
  output logic [swlis_pkg::CNT_W-1:0]           lis_length_o,
  output logic [swlis_pkg::CNT_W-1:0]           window_fill_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [swlis_pkg::ADDR_W-1:0]          paddr,
  input  logic [swlis_pkg::DATA_W-1:0]          pwdata,
  output logic [swlis_pkg::DATA_W-1:0]          prdata,
  output logic                                  pready
);

  localparam int W = swlis_pkg::CNT_W;

  logic [W-1:0] wlen_q, wlen_d;
  logic [W-1:0] eff_len;
  logic         cfg_wr;
  logic         sel_wlen;

  swlis_pkg::dp_cmd_t    cmd;
  swlis_pkg::dp_status_t status;

  assign pready   = 1'b1;
  assign sel_wlen = (paddr[swlis_pkg::ADDR_W-1:2] == swlis_pkg::REG_WINDOW_LEN);
  assign cfg_wr   = psel && penable && pwrite && pready && sel_wlen;
  assign wlen_d   = cfg_wr ? pwdata[W-1:0] : wlen_q;
  assign prdata   = sel_wlen ? swlis_pkg::DATA_W'(wlen_q) : '0;

  always_comb begin
    if (wlen_q == '0) begin
      eff_len = swlis_pkg::MIN_LEN;
    end else if (wlen_q > swlis_pkg::MAX_LEN) begin
      eff_len = swlis_pkg::MAX_LEN;
    end else begin
      eff_len = wlen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= swlis_pkg::MAX_LEN;
    end else begin
      wlen_q <= wlen_d;
    end
  end

  swlis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swlis_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_clear_i   (cfg_wr),
    .eff_len_i     (eff_len),
    .sample_i      (sample_i),
    .lis_length_o  (lis_length_o),
    .window_fill_o (window_fill_o)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sliding_window_lis_length_core. A behavioral window
// model predicts the longest non-decreasing subsequence length and fill
// for every sample taken in. Each result is compared in order against that
// prediction. Window length settings are swept over APB, the extremes and
// the clamped codes included. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_WINDOW = swlis_pkg::MAX_WINDOW;
  localparam int SAMPLE_W   = swlis_pkg::SAMPLE_W;
  localparam int CNT_W      = swlis_pkg::CNT_W;
  localparam int ADDR_W     = swlis_pkg::ADDR_W;
  localparam int DATA_W     = swlis_pkg::DATA_W;

  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TARGET  = 1150;
  localparam int FINAL_ITEMS    = 150;
  localparam int MAX_PRINTS     = 40;

  localparam logic [ADDR_W-1:0] ADDR_WINDOW_LEN = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED     = 3'd4;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum int {
    PAT_RANDOM,
    PAT_SMALL,
    PAT_RISING,
    PAT_EXTREME,
    PAT_FALLING
  } pattern_e;

  typedef struct packed {
    logic [CNT_W-1:0] lis_length;
    logic [CNT_W-1:0] window_fill;
  } lis_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_i      = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [CNT_W-1:0]           lis_length_o;
  logic [CNT_W-1:0]           window_fill_o;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [ADDR_W-1:0]          paddr         = '0;
  logic [DATA_W-1:0]          pwdata        = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // window model state
  logic signed [SAMPLE_W-1:0] window_q[$];
  logic [CNT_W-1:0]           window_len_q = CNT_W'(MAX_WINDOW);
  lis_result_t                expected_results[$];

  logic signed [SAMPLE_W-1:0] ramp_value = '0;
  bit  idling_on    = 1'b1;
  bit  valid_hi     = 1'b0;
  int  in_run_left  = 0;
  int  stall_left   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  mismatches   = 0;
  int  settings_seen = 0;

  sliding_window_lis_length_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .lis_length_o (lis_length_o),
    .window_fill_o(window_fill_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // Push one sample into the window model and recompute the longest
  // non-decreasing subsequence over it, oldest to newest.
  function automatic lis_result_t advance_window(input logic signed [SAMPLE_W-1:0] value);
    int          span;
    int          best;
    int          runs[MAX_WINDOW];
    lis_result_t res;
    if (window_len_q == 0) span = 1;
    else if (window_len_q > MAX_WINDOW) span = MAX_WINDOW;
    else span = int'(window_len_q);
    if (window_q.size() >= span) void'(window_q.pop_front());
    window_q.push_back(value);
    best = 0;
    for (int i = 0; i < window_q.size(); i++) begin
      runs[i] = 1;
      for (int j = 0; j < i; j++)
        if (window_q[j] <= window_q[i] && runs[j] + 1 > runs[i]) runs[i] = runs[j] + 1;
      if (runs[i] > best) best = runs[i];
    end
    res.lis_length  = CNT_W'(best);
    res.window_fill = CNT_W'(window_q.size());
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] gen_sample(input pattern_e pat);
    logic signed [SAMPLE_W-1:0] v;
    if ($urandom_range(0, 9) == 0) return $urandom();
    case (pat)
      PAT_SMALL: v = int'($urandom_range(0, 8)) - 4;
      PAT_RISING: begin
        ramp_value = ramp_value + int'($urandom_range(0, 6)) - 2;
        v = ramp_value;
      end
      PAT_FALLING: begin
        ramp_value = ramp_value - int'($urandom_range(0, 6)) + 2;
        v = ramp_value;
      end
      PAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = SAMPLE_MIN;
          1:       v = SAMPLE_MAX;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // input accept -> predict, output accept -> compare against oldest prediction
  always @(posedge clk_i) begin : scoreboard_monitor
    lis_result_t want;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_results.push_back(advance_window(sample_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(lis_length_o), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (lis_length_o !== want.lis_length)
          report_mismatch("lis_length", 32'(lis_length_o), 32'(want.lis_length));
        if (window_fill_o !== want.window_fill)
          report_mismatch("window_fill", 32'(window_fill_o), 32'(want.window_fill));
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i) begin : out_stall_gen
    if (!idling_on) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 1)) begin
      out_stall_i <= 1'b1;
      stall_left  = $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
      stall_left  = $urandom_range(0, 29);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    in_valid_i <= 1'b1;
    sample_i   <= value;
    valid_hi   = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (in_run_left > 0) begin
      in_run_left--;
    end else if (idling_on) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      sample_i   <= $urandom();
      valid_hi   = 1'b0;
      repeat (gap) @(posedge clk_i);
      in_run_left = $urandom_range(0, 24);
    end
  endtask

  // sender holds off until every predicted result has come back
  task automatic wait_for_results();
    if (valid_hi) begin
      in_valid_i <= 1'b0;
      valid_hi   = 1'b0;
    end
    while (results_seen < items_sent) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // any write to the length register empties the window
    if (addr[ADDR_W-1:2] == swlis_pkg::REG_WINDOW_LEN) begin
      window_len_q = data[CNT_W-1:0];
      window_q.delete();
      settings_seen++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_window_len();
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WINDOW_LEN;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== DATA_W'(window_len_q))
      report_mismatch("window_len readback", got, 32'(window_len_q));
  endtask

  task automatic test_reset_defaults();
    check_window_len();
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(-1);
    wait_for_results();
  endtask

  // 0 acts as 1, codes above the window size act as the full window,
  // bits above the register width are dropped
  task automatic test_window_len_clamp();
    apb_write(ADDR_WINDOW_LEN, '0);
    check_window_len();
    send_sample(5);
    send_sample(-5);
    wait_for_results();
    apb_write(ADDR_WINDOW_LEN, 32'd127);
    check_window_len();
    send_sample(SAMPLE_MAX);
    send_sample(100);
    send_sample(SAMPLE_MIN);
    wait_for_results();
    apb_write(ADDR_WINDOW_LEN, 32'hFFFF_FF82);
    check_window_len();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    wait_for_results();
  endtask

  // write to an unmapped index must leave the window intact
  task automatic test_register_map();
    apb_write(ADDR_UNUSED, 32'd5);
    check_window_len();
    send_sample(-3);
    send_sample(-3);
    wait_for_results();
  endtask

  task automatic test_equal_samples();
    apb_write(ADDR_WINDOW_LEN, 32'd4);
    repeat (5) send_sample(7);
    wait_for_results();
  endtask

  task automatic test_random_stream();
    int                phase_items;
    pattern_e          pat;
    logic [CNT_W-1:0]  len;
    logic [DATA_W-1:0] word;
    while (items_sent < RANDOM_TARGET) begin
      wait_for_results();
      if ($urandom_range(0, 5) == 0) apb_write(ADDR_UNUSED, $urandom());
      case ($urandom_range(0, 9))
        0:       len = CNT_W'(1);
        1:       len = CNT_W'(2);
        2:       len = CNT_W'(MAX_WINDOW);
        3:       len = '0;
        4:       len = CNT_W'($urandom_range(MAX_WINDOW + 1, 127));
        5, 6:    len = CNT_W'($urandom_range(3, 12));
        default: len = CNT_W'($urandom_range(1, MAX_WINDOW));
      endcase
      word = DATA_W'(len);
      if ($urandom_range(0, 1)) begin
        word = $urandom();
        word[CNT_W-1:0] = len;
      end
      apb_write(ADDR_WINDOW_LEN, word);
      check_window_len();
      pat         = pattern_e'($urandom_range(0, 4));
      ramp_value  = $urandom();
      phase_items = $urandom_range(20, 110);
      repeat (phase_items) begin
        send_sample(gen_sample(pat));
        if ($urandom_range(0, 199) == 0) wait_for_results();
      end
    end
    wait_for_results();
  endtask

  // full window, no idling on either side
  task automatic test_final_burst();
    apb_write(ADDR_WINDOW_LEN, DATA_W'(MAX_WINDOW));
    idling_on   = 1'b0;
    in_run_left = 0;
    ramp_value  = $urandom();
    for (int k = 0; k < FINAL_ITEMS; k++)
      send_sample(gen_sample(pattern_e'(k / 30)));
    wait_for_results();
  endtask

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_window_len_clamp();
    test_register_map();
    test_equal_samples();
    test_random_stream();
    test_final_burst();
    // let any stray result show up
    repeat (MAX_WINDOW + 8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 32'd0, expected_results.size());
    $display("Covered %0d window length settings (zero and oversize codes included).",
             settings_seen);
    $display("%0d samples sent, %0d results compared, %0d mismatches.",
             items_sent, results_seen, mismatches);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
